// File: design/pdhc_pkg.sv
// Shared widths, register indexes, codes and reset values of the heater hold-and-capture controller.
`default_nettype none

package pdhc_pkg;

    // Field widths
    localparam int GAIN_W  = 16;
    localparam int LIMIT_W = 8;
    localparam int LEVEL_W = 8;
    localparam int TEMP_W  = 12;
    localparam int HOLD_W  = 20;
    localparam int MEAS_W  = 13;
    localparam int TIME_W  = 32;
    localparam int DRIVE_W = 8;
    localparam int MODE_W  = 2;

    // Internal widths: error spans -4095..8191, the integral saturates at 24 bits
    localparam int ERR_W = 15;
    localparam int SUM_W = 24;
    localparam int ACC_W = 28;                 // high part of the serial MAC
    localparam int CNT_W = $clog2(GAIN_W);
    localparam int X_W   = 10;                 // scaled sum below the full-scale point
    localparam int REM_W = X_W + LIMIT_W;
    localparam int DVS_W = REM_W - 1;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_DRIVE_LIMIT = 3'd3,
        REG_BLUE_EN     = 3'd4,
        REG_RED_EN      = 3'd5,
        REG_BLUE_LEVEL  = 3'd6,
        REG_RED_LEVEL   = 3'd7
    } reg_index_t;

    // Operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Light and picture codes
    localparam logic [MODE_W-1:0] LIGHT_OFF  = 2'd0;
    localparam logic [MODE_W-1:0] LIGHT_BLUE = 2'd1;
    localparam logic [MODE_W-1:0] LIGHT_RED  = 2'd2;
    localparam logic [LEVEL_W-1:0] LED_OFF   = 8'hFF;

    // Control constants
    localparam int DRIVE_SCALE = 1000;
    localparam logic signed [ERR_W-1:0] FAN_ON_ERR = ERR_W'(-80);
    localparam logic signed [ERR_W-1:0] SETTLE_LO  = ERR_W'(-16);
    localparam logic signed [ERR_W-1:0] SETTLE_HI  = ERR_W'(16);

    // Register reset values
    localparam logic [GAIN_W-1:0]  GAIN_P_RST      = 16'd640;
    localparam logic [GAIN_W-1:0]  GAIN_I_RST      = 16'd0;
    localparam logic [GAIN_W-1:0]  GAIN_D_RST      = 16'd12800;
    localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = 8'd75;
    localparam logic               BLUE_EN_RST     = 1'b1;
    localparam logic               RED_EN_RST      = 1'b1;
    localparam logic [LEVEL_W-1:0] BLUE_LEVEL_RST  = 8'd0;
    localparam logic [LEVEL_W-1:0] RED_LEVEL_RST   = 8'd0;

endpackage

`default_nettype wire

// File: design/pdhc_request_if.sv
// Input item channel: valid/ready handshake with start and tick fields.
`default_nettype none

interface pdhc_request_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  operation;
    logic [pdhc_pkg::TEMP_W-1:0]           target_temp;
    logic [pdhc_pkg::HOLD_W-1:0]           hold_ms;
    logic                                  capture_wanted;
    logic signed [pdhc_pkg::MEAS_W-1:0]    measured_temp;
    logic [pdhc_pkg::TIME_W-1:0]           time_ms;
    logic                                  picture_done;

    modport source (
        output valid, operation, target_temp, hold_ms, capture_wanted,
               measured_temp, time_ms, picture_done,
        input  ready
    );

    modport sink (
        input  valid, operation, target_temp, hold_ms, capture_wanted,
               measured_temp, time_ms, picture_done,
        output ready
    );
endinterface

`default_nettype wire

// File: design/pdhc_result_if.sv
// Result item channel: valid/ready handshake with heater, fan, light and capture fields.
`default_nettype none

interface pdhc_result_if;
    logic                                valid;
    logic                                ready;
    logic [pdhc_pkg::DRIVE_W-1:0]        heater_drive;
    logic                                fan_on;
    logic [pdhc_pkg::LEVEL_W-1:0]        blue_led;
    logic [pdhc_pkg::LEVEL_W-1:0]        red_led;
    logic [pdhc_pkg::MODE_W-1:0]         light_mode;
    logic [pdhc_pkg::MODE_W-1:0]         picture_request;
    logic                                step_done;

    modport source (
        output valid, heater_drive, fan_on, blue_led, red_led, light_mode,
               picture_request, step_done,
        input  ready
    );

    modport sink (
        input  valid, heater_drive, fan_on, blue_led, red_led, light_mode,
               picture_request, step_done,
        output ready
    );
endinterface

`default_nettype wire

// File: design/pd_heater_hold_and_capture_controller.sv
// Top level of the heater hold-and-capture controller: control, serial PID MAC and drive scaling.
`default_nettype none

// One result per input item, one item in flight at a time. The request is taken only in idle;
// the result sits in an output register, so the next item can start while it waits. A start
// item, a tick after the step has ended, and the tick that ends the step each pass from the
// execute state straight to the output state. A regulating tick runs the bit-serial MAC, which
// walks the three 16-bit gains one bit per cycle; unless the scaled sum is negative or at the
// limit, it then runs the restoring divider that forms the drive quotient one bit per cycle.
// Register writes are taken at any time through the APB port, which never waits.
module pd_heater_hold_and_capture_controller (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    pdhc_request_if.sink                         request,
    pdhc_result_if.source                        result,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pdhc_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [pdhc_pkg::DATA_W-1:0]     pwdata,
    output logic      [pdhc_pkg::DATA_W-1:0]     prdata,
    output logic                                 pready
);

    localparam int GAIN_W  = pdhc_pkg::GAIN_W;
    localparam int LIMIT_W = pdhc_pkg::LIMIT_W;
    localparam int LEVEL_W = pdhc_pkg::LEVEL_W;
    localparam int TEMP_W  = pdhc_pkg::TEMP_W;
    localparam int HOLD_W  = pdhc_pkg::HOLD_W;
    localparam int MEAS_W  = pdhc_pkg::MEAS_W;
    localparam int TIME_W  = pdhc_pkg::TIME_W;
    localparam int DRIVE_W = pdhc_pkg::DRIVE_W;
    localparam int MODE_W  = pdhc_pkg::MODE_W;
    localparam int ERR_W   = pdhc_pkg::ERR_W;
    localparam int SUM_W   = pdhc_pkg::SUM_W;
    localparam int ACC_W   = pdhc_pkg::ACC_W;
    localparam int CNT_W   = pdhc_pkg::CNT_W;
    localparam int X_W     = pdhc_pkg::X_W;
    localparam int REM_W   = pdhc_pkg::REM_W;
    localparam int DVS_W   = pdhc_pkg::DVS_W;
    localparam int DATA_W  = pdhc_pkg::DATA_W;
    localparam int ADDR_W  = pdhc_pkg::ADDR_W;

    localparam logic [CNT_W-1:0] MAC_LAST = CNT_W'(GAIN_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DRIVE_W - 1);
    localparam logic [DVS_W-1:0] DVS_INIT = DVS_W'(pdhc_pkg::DRIVE_SCALE * (2 ** (DRIVE_W - 1)));
    localparam logic [X_W-1:0]   X_FULL   = X_W'(pdhc_pkg::DRIVE_SCALE);
    localparam logic [SUM_W-1:0] SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MAC,
        S_LIM,
        S_DIV,
        S_OUT
    } state_t;

    // Control and configuration
    state_t                   state_reg, state_next;
    logic                     out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [GAIN_W-1:0]        gain_p_reg, gain_i_reg, gain_d_reg;
    logic [LIMIT_W-1:0]       drive_limit_reg;
    logic                     blue_en_reg, red_en_reg;
    logic [LEVEL_W-1:0]       blue_level_reg, red_level_reg;

    // Step state
    logic [TEMP_W-1:0]        setpoint_reg, setpoint_next;
    logic [HOLD_W-1:0]        hold_reg, hold_next;
    logic signed [ERR_W-1:0]  last_error_reg, last_error_next;
    logic [SUM_W-1:0]         error_sum_reg, error_sum_next;
    logic                     fan_reg, fan_next;
    logic                     settled_reg, settled_next;
    logic [TIME_W-1:0]        settle_time_reg, settle_time_next;
    logic                     blue_pend_reg, blue_pend_next;
    logic                     red_pend_reg, red_pend_next;
    logic                     awaiting_reg, awaiting_next;
    logic                     finished_reg, finished_next;
    logic [MODE_W-1:0]        light_reg, light_next;

    // Latched input item
    logic                     op_reg;
    logic [TEMP_W-1:0]        target_reg;
    logic [HOLD_W-1:0]        hold_in_reg;
    logic                     cap_reg;
    logic [MEAS_W-1:0]        meas_reg;
    logic [TIME_W-1:0]        time_reg;
    logic                     pic_done_reg;

    // Serial datapath
    logic signed [ERR_W-1:0]  deriv_reg, deriv_next;
    logic [GAIN_W-1:0]        gp_sh_reg, gp_sh_next;
    logic [GAIN_W-1:0]        gi_sh_reg, gi_sh_next;
    logic [GAIN_W-1:0]        gd_sh_reg, gd_sh_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [GAIN_W-1:0]        lo_reg, lo_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [DVS_W-1:0]         dvs_reg, dvs_next;
    logic [DRIVE_W-1:0]       quo_reg, quo_next;

    // Pending result and output register
    logic [DRIVE_W-1:0]       res_drive_reg, res_drive_next;
    logic                     res_fan_reg, res_fan_next;
    logic [LEVEL_W-1:0]       res_blue_reg, res_blue_next;
    logic [LEVEL_W-1:0]       res_red_reg, res_red_next;
    logic [MODE_W-1:0]        res_mode_reg, res_mode_next;
    logic [MODE_W-1:0]        res_pic_reg, res_pic_next;
    logic                     res_done_reg, res_done_next;
    logic [DRIVE_W-1:0]       out_drive_reg;
    logic                     out_fan_reg;
    logic [LEVEL_W-1:0]       out_blue_reg, out_red_reg;
    logic [MODE_W-1:0]        out_mode_reg, out_pic_reg;
    logic                     out_done_reg;
    logic                     out_load;

    // Combinational helpers
    logic                     req_xfer;
    logic                     cfg_we;
    logic signed [ERR_W-1:0]  err_w;
    logic signed [ERR_W-1:0]  deriv_w;
    logic [SUM_W:0]           sum_w;
    logic [SUM_W-1:0]         sum_sat;
    logic                     in_band;
    logic [TIME_W-1:0]        elapsed;
    logic                     expired;
    logic [ACC_W-1:0]         p_err, p_sum, p_der, mac_t;
    logic                     x_neg, x_small;
    logic [X_W-1:0]           x_val;
    logic                     div_ge;

    assign req_xfer      = request.valid && request.ready;
    assign request.ready = (state_reg == S_IDLE);
    assign pready        = 1'b1;
    assign cfg_we        = psel && penable && pwrite && pready;

    // Output channel driven from the output register
    assign result.valid           = out_valid_reg;
    assign result.heater_drive    = out_drive_reg;
    assign result.fan_on          = out_fan_reg;
    assign result.blue_led        = out_blue_reg;
    assign result.red_led         = out_red_reg;
    assign result.light_mode      = out_mode_reg;
    assign result.picture_request = out_pic_reg;
    assign result.step_done       = out_done_reg;

    // Error, derivative and saturating integral
    assign err_w   = $signed({{(ERR_W-TEMP_W){1'b0}}, setpoint_reg})
                   - $signed({{(ERR_W-MEAS_W){meas_reg[MEAS_W-1]}}, meas_reg});
    assign deriv_w = err_w - last_error_reg;
    assign sum_w   = {error_sum_reg[SUM_W-1], error_sum_reg}
                   + {{(SUM_W+1-ERR_W){err_w[ERR_W-1]}}, err_w};
    assign sum_sat = (sum_w[SUM_W] != sum_w[SUM_W-1])
                   ? (sum_w[SUM_W] ? SUM_MIN : SUM_MAX) : sum_w[SUM_W-1:0];
    assign in_band = (err_w > pdhc_pkg::SETTLE_LO) && (err_w < pdhc_pkg::SETTLE_HI);

    // Hold timer; a newly settled tick has zero elapsed time, so the old flags suffice
    assign elapsed = time_reg - settle_time_reg;
    assign expired = settled_reg && (elapsed > {{(TIME_W-HOLD_W){1'b0}}, hold_reg});

    // Serial MAC: one bit of each gain per cycle, sum low bits shift out into lo_reg
    assign p_err = gp_sh_reg[0] ? {{(ACC_W-ERR_W){last_error_reg[ERR_W-1]}}, last_error_reg}
                                : '0;
    assign p_sum = gi_sh_reg[0] ? {{(ACC_W-SUM_W){error_sum_reg[SUM_W-1]}}, error_sum_reg}
                                : '0;
    assign p_der = gd_sh_reg[0] ? {{(ACC_W-ERR_W){deriv_reg[ERR_W-1]}}, deriv_reg} : '0;
    assign mac_t = acc_reg + p_err + p_sum + p_der;

    // Sum divided by 256: sign, and whether it stays below 1024
    assign x_neg   = acc_reg[ACC_W-1];
    assign x_small = (acc_reg[ACC_W-1:2] == '0);
    assign x_val   = {acc_reg[1:0], lo_reg[GAIN_W-1:GAIN_W-8]};

    // Restoring divide step
    assign div_ge = (rem_reg >= {1'b0, dvs_reg});

    // Next-state logic
    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg;
        cnt_next         = cnt_reg;
        setpoint_next    = setpoint_reg;
        hold_next        = hold_reg;
        last_error_next  = last_error_reg;
        error_sum_next   = error_sum_reg;
        fan_next         = fan_reg;
        settled_next     = settled_reg;
        settle_time_next = settle_time_reg;
        blue_pend_next   = blue_pend_reg;
        red_pend_next    = red_pend_reg;
        awaiting_next    = awaiting_reg;
        finished_next    = finished_reg;
        light_next       = light_reg;
        deriv_next       = deriv_reg;
        gp_sh_next       = gp_sh_reg;
        gi_sh_next       = gi_sh_reg;
        gd_sh_next       = gd_sh_reg;
        acc_next         = acc_reg;
        lo_next          = lo_reg;
        rem_next         = rem_reg;
        dvs_next         = dvs_reg;
        quo_next         = quo_reg;
        res_drive_next   = res_drive_reg;
        res_fan_next     = res_fan_reg;
        res_blue_next    = res_blue_reg;
        res_red_next     = res_red_reg;
        res_mode_next    = res_mode_reg;
        res_pic_next     = res_pic_reg;
        res_done_next    = res_done_reg;
        out_load         = 1'b0;

        // result leaves on its transfer
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_drive_next = '0;
                state_next     = S_OUT;
                if (op_reg == pdhc_pkg::OP_START)
                begin
                    setpoint_next    = target_reg;
                    hold_next        = hold_in_reg;
                    last_error_next  = '0;
                    error_sum_next   = '0;
                    settled_next     = 1'b0;
                    settle_time_next = '0;
                    blue_pend_next   = cap_reg && blue_en_reg;
                    red_pend_next    = cap_reg && red_en_reg;
                    awaiting_next    = 1'b0;
                    finished_next    = 1'b0;
                    light_next       = pdhc_pkg::LIGHT_OFF;
                    res_fan_next     = fan_reg;
                    res_done_next    = 1'b0;
                    res_pic_next     = pdhc_pkg::LIGHT_OFF;
                end
                else if (finished_reg)
                begin
                    fan_next      = 1'b0;
                    res_fan_next  = 1'b0;
                    res_done_next = 1'b1;
                    res_pic_next  = pdhc_pkg::LIGHT_OFF;
                end
                else
                begin
                    last_error_next = err_w;
                    error_sum_next  = sum_sat;
                    deriv_next      = deriv_w;

                    // fan hysteresis
                    if (err_w < pdhc_pkg::FAN_ON_ERR)
                    begin
                        fan_next = 1'b1;
                    end
                    else if (!err_w[ERR_W-1] && (err_w != '0))
                    begin
                        fan_next = 1'b0;
                    end

                    if (!settled_reg && in_band)
                    begin
                        settled_next     = 1'b1;
                        settle_time_next = time_reg;
                    end

                    // capture sequence after the hold
                    if (expired)
                    begin
                        if (awaiting_reg)
                        begin
                            if (pic_done_reg)
                            begin
                                awaiting_next = 1'b0;
                                light_next    = pdhc_pkg::LIGHT_OFF;
                            end
                        end
                        else if (blue_pend_reg)
                        begin
                            awaiting_next  = 1'b1;
                            light_next     = pdhc_pkg::LIGHT_BLUE;
                            blue_pend_next = 1'b0;
                        end
                        else if (red_pend_reg)
                        begin
                            awaiting_next = 1'b1;
                            light_next    = pdhc_pkg::LIGHT_RED;
                            red_pend_next = 1'b0;
                        end
                        else
                        begin
                            finished_next = 1'b1;
                            fan_next      = 1'b0;
                        end
                    end

                    res_fan_next  = fan_next;
                    res_done_next = finished_next;
                    res_pic_next  = awaiting_next ? light_next : pdhc_pkg::LIGHT_OFF;

                    // the step-end tick drives zero; otherwise run the MAC
                    if (!finished_next)
                    begin
                        gp_sh_next = gain_p_reg;
                        gi_sh_next = gain_i_reg;
                        gd_sh_next = gain_d_reg;
                        acc_next   = '0;
                        cnt_next   = '0;
                        state_next = S_MAC;
                    end
                end

                // light outputs from the updated light state
                res_blue_next = (light_next == pdhc_pkg::LIGHT_BLUE)
                              ? blue_level_reg : pdhc_pkg::LED_OFF;
                res_red_next  = (light_next == pdhc_pkg::LIGHT_RED)
                              ? red_level_reg : pdhc_pkg::LED_OFF;
                res_mode_next = (light_next == pdhc_pkg::LIGHT_BLUE ||
                                 light_next == pdhc_pkg::LIGHT_RED)
                              ? light_next : pdhc_pkg::LIGHT_OFF;
            end

            S_MAC:
            begin
                acc_next   = {mac_t[ACC_W-1], mac_t[ACC_W-1:1]};
                lo_next    = {mac_t[0], lo_reg[GAIN_W-1:1]};
                gp_sh_next = gp_sh_reg >> 1;
                gi_sh_next = gi_sh_reg >> 1;
                gd_sh_next = gd_sh_reg >> 1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == MAC_LAST)
                begin
                    state_next = S_LIM;
                end
            end

            S_LIM:
            begin
                if (x_neg)
                begin
                    res_drive_next = '0;
                    state_next     = S_OUT;
                end
                else if (!x_small || (x_val >= X_FULL))
                begin
                    res_drive_next = drive_limit_reg;
                    state_next     = S_OUT;
                end
                else
                begin
                    rem_next   = REM_W'(x_val) * REM_W'(drive_limit_reg);
                    dvs_next   = DVS_INIT;
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - {1'b0, dvs_reg};
                end
                dvs_next = dvs_reg >> 1;
                quo_next = {quo_reg[DRIVE_W-2:0], div_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    res_drive_next = {quo_reg[DRIVE_W-2:0], div_ge};
                    state_next     = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State machine, step state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
            setpoint_reg    <= '0;
            hold_reg        <= '0;
            last_error_reg  <= '0;
            error_sum_reg   <= '0;
            fan_reg         <= 1'b0;
            settled_reg     <= 1'b0;
            settle_time_reg <= '0;
            blue_pend_reg   <= 1'b0;
            red_pend_reg    <= 1'b0;
            awaiting_reg    <= 1'b0;
            finished_reg    <= 1'b1;
            light_reg       <= pdhc_pkg::LIGHT_OFF;
            gain_p_reg      <= pdhc_pkg::GAIN_P_RST;
            gain_i_reg      <= pdhc_pkg::GAIN_I_RST;
            gain_d_reg      <= pdhc_pkg::GAIN_D_RST;
            drive_limit_reg <= pdhc_pkg::DRIVE_LIMIT_RST;
            blue_en_reg     <= pdhc_pkg::BLUE_EN_RST;
            red_en_reg      <= pdhc_pkg::RED_EN_RST;
            blue_level_reg  <= pdhc_pkg::BLUE_LEVEL_RST;
            red_level_reg   <= pdhc_pkg::RED_LEVEL_RST;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            cnt_reg         <= cnt_next;
            setpoint_reg    <= setpoint_next;
            hold_reg        <= hold_next;
            last_error_reg  <= last_error_next;
            error_sum_reg   <= error_sum_next;
            fan_reg         <= fan_next;
            settled_reg     <= settled_next;
            settle_time_reg <= settle_time_next;
            blue_pend_reg   <= blue_pend_next;
            red_pend_reg    <= red_pend_next;
            awaiting_reg    <= awaiting_next;
            finished_reg    <= finished_next;
            light_reg       <= light_next;

            // register writes
            if (cfg_we)
            begin
                unique case (pdhc_pkg::reg_index_t'(paddr[ADDR_W-1:2]))
                    pdhc_pkg::REG_GAIN_P:      gain_p_reg      <= pwdata[GAIN_W-1:0];
                    pdhc_pkg::REG_GAIN_I:      gain_i_reg      <= pwdata[GAIN_W-1:0];
                    pdhc_pkg::REG_GAIN_D:      gain_d_reg      <= pwdata[GAIN_W-1:0];
                    pdhc_pkg::REG_DRIVE_LIMIT: drive_limit_reg <= pwdata[LIMIT_W-1:0];
                    pdhc_pkg::REG_BLUE_EN:     blue_en_reg     <= pwdata[0];
                    pdhc_pkg::REG_RED_EN:      red_en_reg      <= pwdata[0];
                    pdhc_pkg::REG_BLUE_LEVEL:  blue_level_reg  <= pwdata[LEVEL_W-1:0];
                    pdhc_pkg::REG_RED_LEVEL:   red_level_reg   <= pwdata[LEVEL_W-1:0];
                    default:                   gain_p_reg      <= gain_p_reg;
                endcase
            end
        end
    end

    // Payload: input latch, serial datapath, pending result and output register
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            op_reg       <= request.operation;
            target_reg   <= request.target_temp;
            hold_in_reg  <= request.hold_ms;
            cap_reg      <= request.capture_wanted;
            meas_reg     <= request.measured_temp;
            time_reg     <= request.time_ms;
            pic_done_reg <= request.picture_done;
        end

        deriv_reg     <= deriv_next;
        gp_sh_reg     <= gp_sh_next;
        gi_sh_reg     <= gi_sh_next;
        gd_sh_reg     <= gd_sh_next;
        acc_reg       <= acc_next;
        lo_reg        <= lo_next;
        rem_reg       <= rem_next;
        dvs_reg       <= dvs_next;
        quo_reg       <= quo_next;
        res_drive_reg <= res_drive_next;
        res_fan_reg   <= res_fan_next;
        res_blue_reg  <= res_blue_next;
        res_red_reg   <= res_red_next;
        res_mode_reg  <= res_mode_next;
        res_pic_reg   <= res_pic_next;
        res_done_reg  <= res_done_next;

        if (out_load)
        begin
            out_drive_reg <= res_drive_reg;
            out_fan_reg   <= res_fan_reg;
            out_blue_reg  <= res_blue_reg;
            out_red_reg   <= res_red_reg;
            out_mode_reg  <= res_mode_reg;
            out_pic_reg   <= res_pic_reg;
            out_done_reg  <= res_done_reg;
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (pdhc_pkg::reg_index_t'(paddr[ADDR_W-1:2]))
            pdhc_pkg::REG_GAIN_P:      prdata = DATA_W'(gain_p_reg);
            pdhc_pkg::REG_GAIN_I:      prdata = DATA_W'(gain_i_reg);
            pdhc_pkg::REG_GAIN_D:      prdata = DATA_W'(gain_d_reg);
            pdhc_pkg::REG_DRIVE_LIMIT: prdata = DATA_W'(drive_limit_reg);
            pdhc_pkg::REG_BLUE_EN:     prdata = DATA_W'(blue_en_reg);
            pdhc_pkg::REG_RED_EN:      prdata = DATA_W'(red_en_reg);
            pdhc_pkg::REG_BLUE_LEVEL:  prdata = DATA_W'(blue_level_reg);
            pdhc_pkg::REG_RED_LEVEL:   prdata = DATA_W'(red_level_reg);
            default:                   prdata = '0;
        endcase
    end

    // A finished step never drives the heater
    a_done_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_done_reg |-> out_drive_reg == '0)
        else $error("heater drive nonzero on a finished step");

    // Drive stays within the configured limit
    a_drive_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_drive_reg <= drive_limit_reg)
        else $error("heater drive above drive limit");

    // A pending picture always has a light on
    a_await_light: assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_reg |-> (light_reg == pdhc_pkg::LIGHT_BLUE || light_reg == pdhc_pkg::LIGHT_RED))
        else $error("picture pending with lights off");

    // A step never ends with a picture outstanding
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> !awaiting_reg)
        else $error("step finished while a picture is pending");

    // The MAC runs exactly its bit count, then the range check follows
    a_mac_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MAC && cnt_reg == MAC_LAST |=> state_reg == S_LIM)
        else $error("serial MAC did not end after the last gain bit");

    // A result appears only from the output step of the sequencer
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

endmodule

`default_nettype wire

// File: dv/pd_heater_hold_and_capture_controller_tb.sv
// Self-checking testbench for the heater hold-and-capture controller: stimulus, prediction, checks.
module pd_heater_hold_and_capture_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pdhc_pkg::*;

    // Predictor constants
    localparam longint INTEG_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint INTEG_MIN = -(longint'(1) <<< (SUM_W - 1));
    localparam longint SUM_FRAC  = 256;
    localparam int     WINDUP_TICKS = 1030;

    typedef struct {
        logic                      op;
        logic [TEMP_W-1:0]         target;
        logic [HOLD_W-1:0]         hold;
        logic                      cap;
        logic signed [MEAS_W-1:0]  meas;
        logic [TIME_W-1:0]         stamp;
        logic                      pic_done;
    } hold_item_t;

    typedef struct {
        logic [DRIVE_W-1:0] drive;
        logic               fan;
        logic [LEVEL_W-1:0] blue_led;
        logic [LEVEL_W-1:0] red_led;
        logic [MODE_W-1:0]  mode;
        logic [MODE_W-1:0]  pic_req;
        logic               step_done;
    } heater_out_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    pdhc_request_if req_if();
    pdhc_result_if  res_if();

    pd_heater_hold_and_capture_controller u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_if),
        .result  (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Register shadow
    logic [GAIN_W-1:0]  cfg_gain_p;
    logic [GAIN_W-1:0]  cfg_gain_i;
    logic [GAIN_W-1:0]  cfg_gain_d;
    logic [LIMIT_W-1:0] cfg_limit;
    logic               cfg_blue_en;
    logic               cfg_red_en;
    logic [LEVEL_W-1:0] cfg_blue_level;
    logic [LEVEL_W-1:0] cfg_red_level;

    // Controller state mirror
    logic [TEMP_W-1:0]  ctl_setpoint;
    logic [HOLD_W-1:0]  ctl_hold;
    int                 ctl_prev_err;
    int                 ctl_integral;
    logic               ctl_fan;
    logic               ctl_settled;
    logic [TIME_W-1:0]  ctl_settle_at;
    logic               ctl_blue_due;
    logic               ctl_red_due;
    logic               ctl_waiting_pic;
    logic               ctl_done;
    logic [MODE_W-1:0]  ctl_light;

    hold_item_t   stimulus_items[$];
    heater_out_t  outputs_due[$];
    logic         req_moved;
    int unsigned  fault_count;
    int unsigned  send_idle_pct;
    int unsigned  take_stall_pct;

    always #10 clk = ~clk;

    task automatic log_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endtask

    // Advance the mirrored controller by one item and return the outputs it should show
    function automatic heater_out_t advance_controller(hold_item_t it);
        heater_out_t       o;
        int                err;
        int                deriv;
        longint            integ;
        longint            acc;
        longint            scaled;
        longint            drv;
        logic [TIME_W-1:0] since;
        drv = 0;
        o.pic_req = LIGHT_OFF;
        if (it.op == OP_START) begin
            ctl_setpoint    = it.target;
            ctl_hold        = it.hold;
            ctl_prev_err    = 0;
            ctl_integral    = 0;
            ctl_settled     = 1'b0;
            ctl_settle_at   = '0;
            ctl_blue_due    = it.cap && cfg_blue_en;
            ctl_red_due     = it.cap && cfg_red_en;
            ctl_waiting_pic = 1'b0;
            ctl_done        = 1'b0;
            ctl_light       = LIGHT_OFF;
            o.fan           = ctl_fan;
            o.step_done     = 1'b0;
        end
        else if (ctl_done) begin
            // idle until the next start; fan is dropped
            ctl_fan     = 1'b0;
            o.fan       = 1'b0;
            o.step_done = 1'b1;
        end
        else begin
            err   = int'(ctl_setpoint) - int'(it.meas);
            deriv = err - ctl_prev_err;
            integ = longint'(ctl_integral) + err;
            if (integ > INTEG_MAX) integ = INTEG_MAX;
            if (integ < INTEG_MIN) integ = INTEG_MIN;
            ctl_integral = int'(integ);
            ctl_prev_err = err;

            acc = longint'(cfg_gain_p) * err + longint'(cfg_gain_i) * ctl_integral
                + longint'(cfg_gain_d) * deriv;
            scaled = acc / SUM_FRAC;
            drv = (scaled * longint'(cfg_limit)) / DRIVE_SCALE;
            if (drv > longint'(cfg_limit)) drv = longint'(cfg_limit);
            if (drv < 0) drv = 0;

            // fan hysteresis
            if (err < int'(FAN_ON_ERR)) ctl_fan = 1'b1;
            else if (err > 0) ctl_fan = 1'b0;

            if (!ctl_settled && err < int'(SETTLE_HI) && err > int'(SETTLE_LO)) begin
                ctl_settled   = 1'b1;
                ctl_settle_at = it.stamp;
            end

            // hold expired: run captures in turn, then end the step
            since = it.stamp - ctl_settle_at;
            if (ctl_settled && since > TIME_W'(ctl_hold)) begin
                if (ctl_waiting_pic) begin
                    if (it.pic_done) begin
                        ctl_waiting_pic = 1'b0;
                        ctl_light       = LIGHT_OFF;
                    end
                end
                else if (ctl_blue_due) begin
                    ctl_waiting_pic = 1'b1;
                    ctl_light       = LIGHT_BLUE;
                    ctl_blue_due    = 1'b0;
                end
                else if (ctl_red_due) begin
                    ctl_waiting_pic = 1'b1;
                    ctl_light       = LIGHT_RED;
                    ctl_red_due     = 1'b0;
                end
                else begin
                    ctl_done = 1'b1;
                    ctl_fan  = 1'b0;
                    drv      = 0;
                end
            end
            o.fan       = ctl_fan;
            o.pic_req   = ctl_waiting_pic ? ctl_light : LIGHT_OFF;
            o.step_done = ctl_done;
        end
        o.drive    = drv[DRIVE_W-1:0];
        o.blue_led = (ctl_light == LIGHT_BLUE) ? cfg_blue_level : LED_OFF;
        o.red_led  = (ctl_light == LIGHT_RED) ? cfg_red_level : LED_OFF;
        o.mode     = (ctl_light == LIGHT_BLUE || ctl_light == LIGHT_RED) ? ctl_light : LIGHT_OFF;
        return o;
    endfunction

    // Register write through APB, then read back
    task automatic reg_write(reg_index_t idx, logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] kept;
        case (idx)
            REG_GAIN_P:      begin cfg_gain_p     = val[GAIN_W-1:0];  kept = DATA_W'(cfg_gain_p); end
            REG_GAIN_I:      begin cfg_gain_i     = val[GAIN_W-1:0];  kept = DATA_W'(cfg_gain_i); end
            REG_GAIN_D:      begin cfg_gain_d     = val[GAIN_W-1:0];  kept = DATA_W'(cfg_gain_d); end
            REG_DRIVE_LIMIT: begin cfg_limit      = val[LIMIT_W-1:0]; kept = DATA_W'(cfg_limit); end
            REG_BLUE_EN:     begin cfg_blue_en    = val[0];           kept = DATA_W'(cfg_blue_en); end
            REG_RED_EN:      begin cfg_red_en     = val[0];           kept = DATA_W'(cfg_red_en); end
            REG_BLUE_LEVEL:  begin cfg_blue_level = val[LEVEL_W-1:0]; kept = DATA_W'(cfg_blue_level); end
            default:         begin cfg_red_level  = val[LEVEL_W-1:0]; kept = DATA_W'(cfg_red_level); end
        endcase
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 4);
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== kept)
            log_fault($sformatf("register %s readback: expected %0h, got %0h",
                                idx.name(), kept, prdata));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_regs(logic [GAIN_W-1:0] gp, logic [GAIN_W-1:0] gi,
                                logic [GAIN_W-1:0] gd, logic [LIMIT_W-1:0] lim,
                                logic ben, logic ren,
                                logic [LEVEL_W-1:0] blv, logic [LEVEL_W-1:0] rlv);
        reg_write(REG_GAIN_P, DATA_W'(gp));
        reg_write(REG_GAIN_I, DATA_W'(gi));
        reg_write(REG_GAIN_D, DATA_W'(gd));
        reg_write(REG_DRIVE_LIMIT, DATA_W'(lim));
        reg_write(REG_BLUE_EN, DATA_W'(ben));
        reg_write(REG_RED_EN, DATA_W'(ren));
        reg_write(REG_BLUE_LEVEL, DATA_W'(blv));
        reg_write(REG_RED_LEVEL, DATA_W'(rlv));
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain(int unsigned span);
        return ($urandom_range(3) == 0) ? GAIN_W'($urandom) : GAIN_W'($urandom_range(span));
    endfunction

    // All fields random; callers overwrite the ones that matter
    function automatic hold_item_t random_item();
        hold_item_t it;
        it.op       = 1'($urandom_range(1));
        it.target   = TEMP_W'($urandom);
        it.hold     = HOLD_W'($urandom);
        it.cap      = 1'($urandom_range(1));
        it.meas     = MEAS_W'($urandom);
        it.stamp    = $urandom;
        it.pic_done = 1'($urandom_range(1));
        return it;
    endfunction

    task automatic push_start(logic [TEMP_W-1:0] target, logic [HOLD_W-1:0] hold, logic cap);
        hold_item_t it;
        it        = random_item();
        it.op     = OP_START;
        it.target = target;
        it.hold   = hold;
        it.cap    = cap;
        stimulus_items.push_back(it);
    endtask

    task automatic push_tick(int meas, logic [TIME_W-1:0] stamp, logic pic_done);
        hold_item_t it;
        it          = random_item();
        it.op       = OP_TICK;
        it.meas     = MEAS_W'(meas);
        it.stamp    = stamp;
        it.pic_done = pic_done;
        stimulus_items.push_back(it);
    endtask

    // Hand-picked items: full capture sequence, field extremes, boundaries
    task automatic queue_directed();
        push_tick(0, 0, 1'b1);                         // tick before any start
        push_start(0, 0, 1'b1);
        push_tick(0, 100, 1'b0);                       // settles, hold not yet over
        push_tick(0, 101, 1'b1);                       // done ignored, blue request
        push_tick(0, 102, 1'b0);                       // request held
        push_tick(0, 103, 1'b1);
        push_tick(0, 104, 1'b0);                       // red request
        push_tick(0, 105, 1'b1);
        push_tick(0, 106, 1'b0);                       // step ends
        push_tick(5, 107, 1'b1);                       // idle after step end
        push_start(TEMP_W'(4095), HOLD_W'(20'hFFFFF), 1'b0);
        push_tick(-4096, 32'hFFFF_FFF0, 1'b0);         // largest error
        push_tick(4095, 32'hFFFF_FFFF, 1'b1);
        push_start(0, 1, 1'b1);
        push_tick(4095, 32'hFFFF_FFFE, 1'b0);          // most negative error, fan on
        push_tick(-1, 32'hFFFF_FFFF, 1'b0);            // fan off, settles
        push_tick(0, 32'h0000_0001, 1'b0);             // hold over across wrap
        push_start(2000, 0, 1'b0);                     // start during a capture
        push_tick(2081, 50, 1'b0);                     // just past the fan threshold
        push_start(2000, 0, 1'b0);                     // fan state carried through start
        push_tick(2080, 60, 1'b0);                     // at the threshold: fan stays
        push_tick(2016, 61, 1'b0);                     // settle window edges
        push_tick(1984, 62, 1'b0);
        push_tick(1985, 63, 1'b0);
        push_tick(1985, 64, 1'b1);                     // no captures: step ends
    endtask

    // One hold step: start, then temperatures converging on the setpoint
    task automatic queue_hold_step(int n_ticks);
        int                target;
        int                temp;
        logic [TIME_W-1:0] now;
        target = ($urandom_range(7) == 0) ? int'($urandom_range(4095))
                                          : int'($urandom_range(300, 3000));
        push_start(TEMP_W'(target),
                   ($urandom_range(9) == 0) ? HOLD_W'($urandom) : HOLD_W'($urandom_range(40)),
                   1'($urandom_range(4) != 0));
        now  = $urandom;
        temp = target + int'($urandom_range(1200)) - 600;
        repeat (n_ticks) begin
            now  = now + (($urandom_range(19) == 0) ? $urandom : $urandom_range(12));
            temp = temp + (target - temp) / 2 + int'($urandom_range(10)) - 5;
            if (temp > 4095) temp = 4095;
            if (temp < -4096) temp = -4096;
            push_tick(temp, now, 1'($urandom_range(2) != 0));
        end
    endtask

    // Long run at the largest error so the integral saturates, then error zero
    task automatic queue_integral_windup();
        logic [TIME_W-1:0] now;
        push_start(TEMP_W'(4095), HOLD_W'(20'hFFFFF), 1'b0);
        now = $urandom;
        repeat (WINDUP_TICKS) begin
            now = now + 3;
            push_tick(-4096, now, 1'($urandom_range(1)));
        end
        repeat (4) begin
            now = now + 3;
            push_tick(4095, now, 1'($urandom_range(1)));
        end
    endtask

    task automatic queue_random_traffic(int budget);
        int count;
        int n;
        count = 0;
        while (count < budget) begin
            if ($urandom_range(9) == 0) begin
                stimulus_items.push_back(random_item());
                count++;
            end
            else begin
                n = int'($urandom_range(3, 30));
                queue_hold_step(n);
                count += n + 1;
            end
        end
    endtask

    // Wait until every queued item is through and every result is back
    task automatic drain_outputs();
        while (stimulus_items.size() != 0 || req_if.valid || outputs_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Request driver and result stalls
    always @(negedge clk) begin
        hold_item_t nxt;
        if (!rst_n) begin
            req_if.valid <= 1'b0;
            res_if.ready <= 1'b0;
        end
        else begin
            if (!req_if.valid || req_moved) begin
                if (stimulus_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = stimulus_items.pop_front();
                    req_if.valid          <= 1'b1;
                    req_if.operation      <= nxt.op;
                    req_if.target_temp    <= nxt.target;
                    req_if.hold_ms        <= nxt.hold;
                    req_if.capture_wanted <= nxt.cap;
                    req_if.measured_temp  <= nxt.meas;
                    req_if.time_ms        <= nxt.stamp;
                    req_if.picture_done   <= nxt.pic_done;
                end
                else begin
                    req_if.valid <= 1'b0;
                end
            end
            res_if.ready <= ($urandom_range(99) >= take_stall_pct);
        end
    end

    // Result checks and prediction on each request transfer
    always @(posedge clk) begin : watch_outputs
        heater_out_t seen;
        heater_out_t want;
        hold_item_t  taken;
        if (rst_n) begin
            if (res_if.valid && res_if.ready) begin
                seen.drive     = res_if.heater_drive;
                seen.fan       = res_if.fan_on;
                seen.blue_led  = res_if.blue_led;
                seen.red_led   = res_if.red_led;
                seen.mode      = res_if.light_mode;
                seen.pic_req   = res_if.picture_request;
                seen.step_done = res_if.step_done;
                if (outputs_due.size() == 0) begin
                    log_fault("result transfer with no expected result");
                end
                else begin
                    want = outputs_due.pop_front();
                    if (seen.drive !== want.drive || seen.fan !== want.fan
                        || seen.blue_led !== want.blue_led || seen.red_led !== want.red_led
                        || seen.mode !== want.mode || seen.pic_req !== want.pic_req
                        || seen.step_done !== want.step_done)
                        log_fault($sformatf({"mismatch at %0t: expected drive=%0d fan=%0b ",
                            "blue=%0d red=%0d mode=%0d req=%0d done=%0b; got drive=%0d fan=%0b ",
                            "blue=%0d red=%0d mode=%0d req=%0d done=%0b"}, $realtime,
                            want.drive, want.fan, want.blue_led, want.red_led, want.mode,
                            want.pic_req, want.step_done, seen.drive, seen.fan, seen.blue_led,
                            seen.red_led, seen.mode, seen.pic_req, seen.step_done));
                end
            end
            if (req_if.valid && req_if.ready) begin
                taken.op       = req_if.operation;
                taken.target   = req_if.target_temp;
                taken.hold     = req_if.hold_ms;
                taken.cap      = req_if.capture_wanted;
                taken.meas     = req_if.measured_temp;
                taken.stamp    = req_if.time_ms;
                taken.pic_done = req_if.picture_done;
                outputs_due.push_back(advance_controller(taken));
            end
            req_moved <= req_if.valid && req_if.ready;
        end
    end

    // Run limit
    initial begin
        #(20_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        clk    = 1'b0;
        rst_n  = 1'b0;
        psel   = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr  = '0;
        pwdata = '0;
        req_if.valid          = 1'b0;
        req_if.operation      = OP_START;
        req_if.target_temp    = '0;
        req_if.hold_ms        = '0;
        req_if.capture_wanted = 1'b0;
        req_if.measured_temp  = '0;
        req_if.time_ms        = '0;
        req_if.picture_done   = 1'b0;
        res_if.ready          = 1'b0;
        req_moved      = 1'b0;
        fault_count    = 0;
        send_idle_pct  = 0;
        take_stall_pct = 0;

        cfg_gain_p     = GAIN_P_RST;
        cfg_gain_i     = GAIN_I_RST;
        cfg_gain_d     = GAIN_D_RST;
        cfg_limit      = DRIVE_LIMIT_RST;
        cfg_blue_en    = BLUE_EN_RST;
        cfg_red_en     = RED_EN_RST;
        cfg_blue_level = BLUE_LEVEL_RST;
        cfg_red_level  = RED_LEVEL_RST;

        ctl_setpoint    = '0;
        ctl_hold        = '0;
        ctl_prev_err    = 0;
        ctl_integral    = 0;
        ctl_fan         = 1'b0;
        ctl_settled     = 1'b0;
        ctl_settle_at   = '0;
        ctl_blue_due    = 1'b0;
        ctl_red_due     = 1'b0;
        ctl_waiting_pic = 1'b0;
        ctl_done        = 1'b1;
        ctl_light       = LIGHT_OFF;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Each phase: new settings while idle, new idling mix, then traffic
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: program_regs(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, DRIVE_LIMIT_RST,
                                BLUE_EN_RST, RED_EN_RST, BLUE_LEVEL_RST, RED_LEVEL_RST);
                1: program_regs('1, '1, '1, '1, 1'b1, 1'b1, '1, '1);
                2: program_regs('0, '0, '0, '0, 1'b0, 1'b0, '0, '0);
                // small integral gain so a saturated integral shows in the drive
                3: program_regs(0, 1, 1000, 255, 1'($urandom_range(1)),
                                1'($urandom_range(1)), LEVEL_W'($urandom), LEVEL_W'($urandom));
                default: program_regs(pick_gain(1500), pick_gain(40), pick_gain(15000),
                                      LIMIT_W'($urandom), 1'($urandom_range(1)),
                                      1'($urandom_range(1)), LEVEL_W'($urandom),
                                      LEVEL_W'($urandom));
            endcase
            case (ph % 4)
                0:       begin send_idle_pct = 0;  take_stall_pct = 0;  end
                1:       begin send_idle_pct = 79; take_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  take_stall_pct = 79; end
                default: begin send_idle_pct = 16; take_stall_pct = 16; end
            endcase
            if (ph == 0)
                queue_directed();
            if (ph == 3) begin
                queue_integral_windup();
                queue_random_traffic(40);
            end
            else begin
                queue_random_traffic(110);
            end
            drain_outputs();
        end

        repeat (40) @(posedge clk);
        if (outputs_due.size() != 0)
            log_fault($sformatf("%0d expected results never arrived", outputs_due.size()));
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
design/pdhc_pkg.sv
design/pdhc_request_if.sv
design/pdhc_result_if.sv
design/pd_heater_hold_and_capture_controller.sv
dv/pd_heater_hold_and_capture_controller_tb.sv
